@@ design/itrd_pkg.sv @@
// Shared types, constants and lookup functions for the integer-to-radix digit converter.
// Used by the controller, the datapath and the top level. No dependencies.
package itrd_pkg;

	localparam int VALUE_W        = 31;
	localparam int BASE_W         = 6;
	localparam int CHAR_W         = 7;
	localparam int COUNT_W        = 5;
	localparam int RECIP_W        = 32;
	localparam int MAX_DIGITS_DEF = 31;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic fix;
		logic read;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic rd_last;
	} status_t;

	// Floor of 2^32 divided by the base. The quotient estimate taken from it is
	// at most one below the true quotient for any 31-bit dividend.
	function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] b);
		logic [RECIP_W-1:0] r;
		begin
			case (b)
				6'd2:    r = 32'd2147483648;
				6'd3:    r = 32'd1431655765;
				6'd4:    r = 32'd1073741824;
				6'd5:    r = 32'd858993459;
				6'd6:    r = 32'd715827882;
				6'd7:    r = 32'd613566756;
				6'd8:    r = 32'd536870912;
				6'd9:    r = 32'd477218588;
				6'd10:   r = 32'd429496729;
				6'd11:   r = 32'd390451572;
				6'd12:   r = 32'd357913941;
				6'd13:   r = 32'd330382099;
				6'd14:   r = 32'd306783378;
				6'd15:   r = 32'd286331153;
				6'd16:   r = 32'd268435456;
				6'd17:   r = 32'd252645135;
				6'd18:   r = 32'd238609294;
				6'd19:   r = 32'd226050910;
				6'd20:   r = 32'd214748364;
				6'd21:   r = 32'd204522252;
				6'd22:   r = 32'd195225786;
				6'd23:   r = 32'd186737708;
				6'd24:   r = 32'd178956970;
				6'd25:   r = 32'd171798691;
				6'd26:   r = 32'd165191049;
				6'd27:   r = 32'd159072862;
				6'd28:   r = 32'd153391689;
				6'd29:   r = 32'd148102320;
				6'd30:   r = 32'd143165576;
				6'd31:   r = 32'd138547332;
				6'd32:   r = 32'd134217728;
				6'd33:   r = 32'd130150524;
				6'd34:   r = 32'd126322567;
				6'd35:   r = 32'd122713351;
				6'd36:   r = 32'd119304647;
				default: r = 32'd119304647;
			endcase
			return r;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		begin
			if (d < 6'd10) begin
				c = CHAR_ZERO + CHAR_W'(d);
			end else begin
				c = CHAR_A + CHAR_W'(d - 6'd10);
			end
			return c;
		end
	endfunction

endpackage

@@ design/itrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/itrd_ctrl.sv @@
// Controller state machine for the digit converter: sequences the divide steps,
// the buffer read-out and the result strobes. Depends on itrd_pkg.
module itrd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  itrd_pkg::status_t status,
	output itrd_pkg::cmd_t    cmd,
	output logic              busy
);

	itrd_pkg::state_t state_q;
	itrd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itrd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = itrd_pkg::ST_MUL;
				end
			end
			itrd_pkg::ST_MUL: begin
				state_d = itrd_pkg::ST_FIX;
			end
			itrd_pkg::ST_FIX: begin
				if (status.div_done) begin
					state_d = itrd_pkg::ST_READ;
				end else begin
					state_d = itrd_pkg::ST_MUL;
				end
			end
			itrd_pkg::ST_READ: begin
				state_d = itrd_pkg::ST_EMIT;
			end
			itrd_pkg::ST_EMIT: begin
				if (status.rd_last) begin
					state_d = itrd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itrd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			itrd_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			itrd_pkg::ST_MUL:  cmd.mul  = 1'b1;
			itrd_pkg::ST_FIX:  cmd.fix  = 1'b1;
			itrd_pkg::ST_READ: cmd.read = 1'b1;
			itrd_pkg::ST_EMIT: cmd.emit = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ design/itrd_dpath.sv @@
// Datapath for the digit converter: reciprocal-multiply divide step, digit buffer
// and reverse read-out. Depends on itrd_pkg and itrd_ram.
module itrd_dpath #(
	parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  itrd_pkg::cmd_t                    cmd,
	input  logic [itrd_pkg::VALUE_W-1:0]      value,
	input  logic [itrd_pkg::BASE_W-1:0]       base,
	output itrd_pkg::status_t                 status,
	output logic [itrd_pkg::CHAR_W-1:0]       digit_char,
	output logic [itrd_pkg::COUNT_W-1:0]      digit_count,
	output logic                              last
);

	localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int VW     = itrd_pkg::VALUE_W;
	localparam int BW     = itrd_pkg::BASE_W;
	localparam int RW     = itrd_pkg::RECIP_W;

	logic [VW-1:0]     num_q;
	logic [BW-1:0]     base_q;
	logic [RW-1:0]     recip_q;
	logic [VW-1:0]     qest_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] rd_ptr_q;

	logic [BW-1:0]     base_clamped;
	logic [VW+RW-1:0]  prod;
	logic [VW+BW-1:0]  qb_full;
	logic [BW:0]       rem_est;
	logic              rem_ge;
	logic [BW-1:0]     rem;
	logic [VW-1:0]     quot;
	logic [ADDR_W-1:0] raddr;

	always_comb begin
		if (base < itrd_pkg::BASE_MIN) begin
			base_clamped = itrd_pkg::BASE_MIN;
		end else if (base > itrd_pkg::BASE_MAX) begin
			base_clamped = itrd_pkg::BASE_MAX;
		end else begin
			base_clamped = base;
		end
	end

	assign prod = (VW + RW)'(num_q) * (VW + RW)'(recip_q);

	// The estimate is short by at most one, so the remainder lies below twice the base.
	assign qb_full = (VW + BW)'(qest_q) * (VW + BW)'(base_q);
	assign rem_est = (BW + 1)'(num_q - qb_full[VW-1:0]);
	assign rem_ge  = (rem_est >= {1'b0, base_q});
	assign rem     = rem_ge ? BW'(rem_est - {1'b0, base_q}) : rem_est[BW-1:0];
	assign quot    = rem_ge ? qest_q + VW'(1) : qest_q;

	assign status.div_done = (quot == '0) || (count_q == CNT_W'(MAX_DIGITS - 1));
	assign status.rd_last  = (rd_ptr_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q   <= value;
			base_q  <= base_clamped;
			recip_q <= itrd_pkg::recip(base_clamped);
		end else if (cmd.fix) begin
			num_q <= quot;
		end
		if (cmd.mul) begin
			qest_q <= prod[VW+RW-1:RW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
			end else if (cmd.fix) begin
				count_q  <= count_q + CNT_W'(1);
				rd_ptr_q <= count_q[ADDR_W-1:0];
			end else if (cmd.emit && !status.rd_last) begin
				rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
			end
		end
	end

	// While emitting, fetch the next lower digit so one word leaves per cycle.
	assign raddr = (cmd.emit && !status.rd_last) ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q;

	itrd_ram #(
		.WIDTH(itrd_pkg::CHAR_W),
		.DEPTH(MAX_DIGITS)
	) u_buf (
		.clk   (clk),
		.we    (cmd.fix),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (itrd_pkg::ascii_of(rem)),
		.raddr (raddr),
		.rdata (digit_char)
	);

	assign last        = status.rd_last;
	assign digit_count = status.rd_last ? itrd_pkg::COUNT_W'(count_q) : '0;

endmodule

@@ design/integer_to_radix_digits_top.sv @@
// Top level of the integer-to-radix digit converter.
// Depends on itrd_pkg, itrd_ctrl, itrd_dpath and itrd_ram.
//
// Usage:
//   Present value and base with start high; the word is taken at a clock edge
//   where start is high and busy is low. Bases below 2 act as 2, above 36 as 36.
//   The digits leave most significant first as ASCII on digit_char, one per
//   cycle, each marked by strobe for exactly one cycle. The final digit has
//   last high and carries the digit count on digit_count (zero otherwise).
//   The receiver cannot stall; every strobed word must be taken.
// Sequence, for a number of n digits:
//   Each digit is produced by a divide step in ST_MUL (reciprocal multiply),
//   then ST_FIX (multiply-back and correction), repeated for all n digits.
//   ST_READ then reads the first digit out of the digit buffer, and n strobes follow.
//   busy stays high from the accept through the last strobe, and the next word
//   can be accepted once busy has fallen.
//   One item is in flight at a time; the divide steps and the read-out set the pace.
// Reset:
//   arst_n low returns the controller to idle at once; no clearing pass.
module integer_to_radix_digits_top #(
	parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [itrd_pkg::VALUE_W-1:0]  value,
	input  logic [itrd_pkg::BASE_W-1:0]   base,
	output logic                          strobe,
	output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
	output logic [itrd_pkg::COUNT_W-1:0]  digit_count,
	output logic                          last
);

	itrd_pkg::cmd_t    cmd;
	itrd_pkg::status_t status;

	itrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	itrd_dpath #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.base        (base),
		.status      (status),
		.digit_char  (digit_char),
		.digit_count (digit_count),
		.last        (last)
	);

	assign strobe = cmd.emit;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for integer_to_radix_digits_top: directed and random words,
// each predicted as its ASCII digit sequence and compared digit by digit.
// Depends on itrd_pkg and the integer_to_radix_digits_top design files.
module tb_top;

	localparam int VALUE_W     = itrd_pkg::VALUE_W;
	localparam int BASE_W      = itrd_pkg::BASE_W;
	localparam int CHAR_W      = itrd_pkg::CHAR_W;
	localparam int COUNT_W     = itrd_pkg::COUNT_W;
	localparam int DIGIT_LIMIT = itrd_pkg::MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 50;

	localparam logic [CHAR_W-1:0]  ASC_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0]  ASC_A     = 7'd65;
	localparam logic [VALUE_W-1:0] VALUE_TOP = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic [COUNT_W-1:0] cnt;
		logic               fin;
	} digit_word_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic [BASE_W-1:0]  base;
	logic               strobe;
	logic [CHAR_W-1:0]  digit_char;
	logic [COUNT_W-1:0] digit_count;
	logic               last;

	digit_word_t digits_due[$];
	int          mismatches = 0;
	int          cycles     = 0;
	bit          idle_on    = 1'b0;
	int          burst_left = 0;

	integer_to_radix_digits_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.base        (base),
		.strobe      (strobe),
		.digit_char  (digit_char),
		.digit_count (digit_count),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
		end
	endtask

	// Digits come out of the division least significant first, so each one is
	// pushed to the front and the list ends up most significant first.
	function automatic void predict_digits(input logic [VALUE_W-1:0] v,
			input logic [BASE_W-1:0] b);
		logic [31:0]       rest;
		logic [31:0]       radix;
		logic [31:0]       d;
		logic [CHAR_W-1:0] msd_first[$];
		digit_word_t       w;
		int                n;
		if (b < itrd_pkg::BASE_MIN) begin
			radix = 32'd2;
		end else if (b > itrd_pkg::BASE_MAX) begin
			radix = 32'd36;
		end else begin
			radix = 32'(b);
		end
		rest = 32'(v);
		n = 0;
		do begin
			d = rest % radix;
			if (d < 32'd10) begin
				msd_first.push_front(ASC_ZERO + CHAR_W'(d));
			end else begin
				msd_first.push_front(ASC_A + CHAR_W'(d - 32'd10));
			end
			rest = rest / radix;
			n++;
		end while (rest != 0 && n < DIGIT_LIMIT);
		for (int k = 0; k < n; k++) begin
			w.ch  = msd_first[k];
			w.fin = (k == n - 1);
			w.cnt = w.fin ? COUNT_W'(n) : '0;
			digits_due.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		digit_word_t want;
		if (arst_n && strobe) begin
			if (digits_due.size() == 0) begin
				report($sformatf("digit word 0x%0h with none expected", digit_char));
			end else begin
				want = digits_due.pop_front();
				if (digit_char !== want.ch) begin
					report($sformatf("digit_char got 0x%0h, expected 0x%0h",
						digit_char, want.ch));
				end
				if (digit_count !== want.cnt) begin
					report($sformatf("digit_count got %0d, expected %0d",
						digit_count, want.cnt));
				end
				if (last !== want.fin) begin
					report($sformatf("last got %0b, expected %0b", last, want.fin));
				end
			end
		end
	end

	// Ends a burst now and then; during the gap start is low and the fields
	// carry junk that the block must ignore. Returns at once while idling is off or the burst goes on.
	task automatic pace();
		int gap;
		if (!idle_on) begin
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 7);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 110) : $urandom_range(1, 8);
		start <= 1'b0;
		value <= VALUE_W'($urandom);
		base  <= BASE_W'($urandom);
		repeat (gap) @(posedge clk);
	endtask

	// Called just after a rising edge; returns just after the accepting edge, or after the gap pace adds.
	task automatic send_word(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
		start <= 1'b1;
		value <= v;
		base  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_digits(v, b);
		pace();
	endtask

	task automatic test_field_extremes();
		send_word('0, 6'd2);
		send_word('0, 6'd36);
		send_word(VALUE_TOP, 6'd2);
		send_word(VALUE_TOP, 6'd36);
		send_word(VALUE_TOP, 6'd10);
		send_word(31'd35, 6'd36);
		send_word(31'd1, 6'd2);
		send_word(31'd10, 6'd10);
		send_word(31'hFF, 6'd16);
		send_word(31'd36, 6'd36);
	endtask

	task automatic test_base_clamping();
		send_word(31'd5, 6'd0);
		send_word(31'h55, 6'd1);
		send_word(31'd1295, 6'd37);
		send_word(VALUE_TOP, 6'd63);
		send_word(31'd123, 6'd62);
	endtask

	// The largest power of the base that fits, and one below it, sit on either
	// side of a change in the digit count.
	task automatic test_digit_count_edges();
		int     radixes[5] = '{3, 7, 10, 16, 35};
		longint p;
		foreach (radixes[i]) begin
			p = 1;
			while (p * radixes[i] <= longint'(VALUE_TOP)) p = p * radixes[i];
			send_word(VALUE_W'(p - 1), BASE_W'(radixes[i]));
			send_word(VALUE_W'(p), BASE_W'(radixes[i]));
		end
	endtask

	task automatic test_random_traffic(input int count);
		logic [VALUE_W-1:0] v;
		logic [BASE_W-1:0]  b;
		for (int i = 0; i < count; i++) begin
			idle_on = (i % 120) < 80;
			case ($urandom_range(0, 3))
				0: v = VALUE_W'($urandom);
				1: v = VALUE_W'($urandom) >> $urandom_range(0, 30);
				2: v = VALUE_W'($urandom_range(0, 100));
				default: v = VALUE_W'($urandom) | (VALUE_W'(1) << (VALUE_W - 1));
			endcase
			if ($urandom_range(0, 7) == 0) begin
				b = BASE_W'($urandom_range(0, 63));
			end else begin
				b = BASE_W'($urandom_range(2, 36));
			end
			send_word(v, b);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		base   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b0;
		test_field_extremes();
		test_base_clamping();
		test_digit_count_edges();
		test_random_traffic(285);

		start <= 1'b0;
		while (digits_due.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/itrd_pkg.sv
design/itrd_ram.sv
design/itrd_ctrl.sv
design/itrd_dpath.sv
design/integer_to_radix_digits_top.sv
tb/tb_top.sv
